### sv/pbsd_pkg.sv
`default_nettype none

package pbsd_pkg;

    // Field widths
    localparam int LevelW = 12;
    localparam int TickW  = 16;
    localparam int PhaseW = 2;

    // APB register map
    localparam int AddrW = 5;
    localparam int DataW = 32;
    localparam int IdxW  = 3;

    localparam logic [IdxW-1:0] REG_PRESS_THRESHOLD = 3'd0;
    localparam logic [IdxW-1:0] REG_RELEASE_WINDOW  = 3'd1;
    localparam logic [IdxW-1:0] REG_HOLD_TIME       = 3'd2;
    localparam logic [IdxW-1:0] REG_ESTOP_LIMIT     = 3'd3;
    localparam logic [IdxW-1:0] REG_FAULT_HOLD_TIME = 3'd4;
    localparam logic [IdxW-1:0] REG_BUTTON_MODE     = 3'd5;

    // Register reset values
    localparam logic [LevelW-1:0] RstPressThreshold = 12'd2000;
    localparam logic [TickW-1:0]  RstReleaseWindow  = 16'd1000;
    localparam logic [TickW-1:0]  RstHoldTime       = 16'd2000;
    localparam logic [TickW-1:0]  RstEstopLimit     = 16'd10;
    localparam logic [TickW-1:0]  RstFaultHoldTime  = 16'd3000;

    // Reported phase codes
    localparam logic [PhaseW-1:0] PH_CODE_IDLE     = 2'd0;
    localparam logic [PhaseW-1:0] PH_CODE_FIRST    = 2'd1;
    localparam logic [PhaseW-1:0] PH_CODE_RELEASED = 2'd2;
    localparam logic [PhaseW-1:0] PH_CODE_SECOND   = 2'd3;

    // Sequencer state, one-hot
    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_FIRST    = 4'b0010,
        ST_RELEASED = 4'b0100,
        ST_SECOND   = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [LevelW-1:0] switch_level;
        logic [TickW-1:0]  tick_now;
    } t_in_beat;

    typedef struct packed {
        logic              shutdown_request;
        logic              fault_reset;
        logic [PhaseW-1:0] sequence_phase;
    } t_out_beat;

endpackage

`default_nettype wire

### sv/power_button_sequence_detector_top.sv
`default_nettype none

// Channel   Direction  Handshake                 Payload
// in        input      i_in_valid / o_in_ready   i_in_data  (pbsd_pkg::t_in_beat)
// out       output     o_out_valid / i_out_ready o_out_data (pbsd_pkg::t_out_beat)
// cfg       input      psel/penable/pwrite/pready paddr, pwdata, prdata
//
// One beat per cycle sustained while the output is not stalled; a beat passes
// through the input register, then the result register holding updated state.
// Sequencer state updates when a beat moves from the input register into the
// result register. Reset (synchronous, active low) clears valid flags and
// detector state and restores register defaults. A stalled output holds both
// stages; the input side keeps accepting while either stage has room.

module power_button_sequence_detector_top (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_in_valid,
    output logic                           o_in_ready,
    input  pbsd_pkg::t_in_beat             i_in_data,
    output logic                           o_out_valid,
    input  wire                            i_out_ready,
    output pbsd_pkg::t_out_beat            o_out_data,
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire  [pbsd_pkg::AddrW-1:0]     paddr,
    input  wire  [pbsd_pkg::DataW-1:0]     pwdata,
    output logic [pbsd_pkg::DataW-1:0]     prdata,
    output logic                           pready
);

    // Configuration registers
    logic [pbsd_pkg::LevelW-1:0] r_press_threshold;
    logic [pbsd_pkg::TickW-1:0]  r_release_window;
    logic [pbsd_pkg::TickW-1:0]  r_hold_time;
    logic [pbsd_pkg::TickW-1:0]  r_estop_limit;
    logic [pbsd_pkg::TickW-1:0]  r_fault_hold_time;
    logic                        r_button_mode;

    // Pipeline registers
    logic                 r_in_valid;
    pbsd_pkg::t_in_beat   r_in_beat;
    logic                 r_out_valid;
    pbsd_pkg::t_out_beat  r_out_beat;

    // Detector state
    pbsd_pkg::t_phase            r_phase, n_phase;
    logic [pbsd_pkg::TickW-1:0]  r_phase_start, n_phase_start;
    logic [pbsd_pkg::TickW-1:0]  r_fault_start, n_fault_start;
    logic                        r_shutdown, n_shutdown;

    logic                        out_room;
    logic                        advance;
    logic                        pressed;
    logic [pbsd_pkg::TickW-1:0]  phase_dt;
    logic [pbsd_pkg::TickW-1:0]  fault_dt;
    logic                        n_fault;
    logic [pbsd_pkg::PhaseW-1:0] n_phase_code;
    logic                        cfg_write;
    logic [pbsd_pkg::IdxW-1:0]   cfg_idx;

    // Handshake: result register frees when taken, input register when moved on
    assign out_room    = !r_out_valid || i_out_ready;
    assign advance     = r_in_valid && out_room;
    assign o_in_ready  = !r_in_valid || out_room;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_beat;

    // APB decode
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[pbsd_pkg::AddrW-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    // Read back
    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            pbsd_pkg::REG_PRESS_THRESHOLD:
                prdata = {{(pbsd_pkg::DataW-pbsd_pkg::LevelW){1'b0}}, r_press_threshold};
            pbsd_pkg::REG_RELEASE_WINDOW:
                prdata = {{(pbsd_pkg::DataW-pbsd_pkg::TickW){1'b0}}, r_release_window};
            pbsd_pkg::REG_HOLD_TIME:
                prdata = {{(pbsd_pkg::DataW-pbsd_pkg::TickW){1'b0}}, r_hold_time};
            pbsd_pkg::REG_ESTOP_LIMIT:
                prdata = {{(pbsd_pkg::DataW-pbsd_pkg::TickW){1'b0}}, r_estop_limit};
            pbsd_pkg::REG_FAULT_HOLD_TIME:
                prdata = {{(pbsd_pkg::DataW-pbsd_pkg::TickW){1'b0}}, r_fault_hold_time};
            pbsd_pkg::REG_BUTTON_MODE:
                prdata = {{(pbsd_pkg::DataW-1){1'b0}}, r_button_mode};
            default: prdata = '0;
        endcase
    end

    // Write configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_threshold <= pbsd_pkg::RstPressThreshold;
            r_release_window  <= pbsd_pkg::RstReleaseWindow;
            r_hold_time       <= pbsd_pkg::RstHoldTime;
            r_estop_limit     <= pbsd_pkg::RstEstopLimit;
            r_fault_hold_time <= pbsd_pkg::RstFaultHoldTime;
            r_button_mode     <= 1'b0;
        end else if (cfg_write) begin
            unique case (cfg_idx)
                pbsd_pkg::REG_PRESS_THRESHOLD:
                    r_press_threshold <= pwdata[pbsd_pkg::LevelW-1:0];
                pbsd_pkg::REG_RELEASE_WINDOW:
                    r_release_window <= pwdata[pbsd_pkg::TickW-1:0];
                pbsd_pkg::REG_HOLD_TIME:
                    r_hold_time <= pwdata[pbsd_pkg::TickW-1:0];
                pbsd_pkg::REG_ESTOP_LIMIT:
                    r_estop_limit <= pwdata[pbsd_pkg::TickW-1:0];
                pbsd_pkg::REG_FAULT_HOLD_TIME:
                    r_fault_hold_time <= pwdata[pbsd_pkg::TickW-1:0];
                pbsd_pkg::REG_BUTTON_MODE:
                    r_button_mode <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Elapsed times wrap modulo the tick width
    assign pressed  = r_in_beat.switch_level >= r_press_threshold;
    assign phase_dt = r_in_beat.tick_now - r_phase_start;
    assign fault_dt = r_in_beat.tick_now - r_fault_start;

    // Next detector state for the beat in the input register
    always_comb begin
        n_phase       = r_phase;
        n_phase_start = r_phase_start;
        n_shutdown    = r_shutdown;
        if (!r_shutdown) begin
            if (!r_button_mode) begin
                unique case (r_phase)
                    pbsd_pkg::ST_IDLE: begin
                        if (pressed) begin
                            n_phase       = pbsd_pkg::ST_FIRST;
                            n_phase_start = r_in_beat.tick_now;
                        end
                    end
                    pbsd_pkg::ST_FIRST: begin
                        if (phase_dt > r_release_window) begin
                            n_phase = pbsd_pkg::ST_IDLE;
                        end else if (!pressed) begin
                            n_phase       = pbsd_pkg::ST_RELEASED;
                            n_phase_start = r_in_beat.tick_now;
                        end
                    end
                    pbsd_pkg::ST_RELEASED: begin
                        if (phase_dt > r_release_window) begin
                            n_phase = pbsd_pkg::ST_IDLE;
                        end else if (pressed) begin
                            n_phase       = pbsd_pkg::ST_SECOND;
                            n_phase_start = r_in_beat.tick_now;
                        end
                    end
                    pbsd_pkg::ST_SECOND: begin
                        if (!pressed) begin
                            n_phase = pbsd_pkg::ST_IDLE;
                        end else if (phase_dt > r_hold_time) begin
                            n_shutdown = 1'b1;
                        end
                    end
                    default: n_phase = pbsd_pkg::ST_IDLE;
                endcase
            end else begin
                // E-stop: track the press, trip on a long release
                if (pressed) begin
                    n_phase_start = r_in_beat.tick_now;
                end else if (phase_dt > r_estop_limit) begin
                    n_shutdown = 1'b1;
                end
            end
        end
    end

    // Fault reset runs regardless of the latch
    always_comb begin
        n_fault       = 1'b0;
        n_fault_start = r_fault_start;
        if (pressed) begin
            n_fault = fault_dt > r_fault_hold_time;
        end else begin
            n_fault_start = r_in_beat.tick_now;
        end
    end

    // Map one-hot state to the reported code
    always_comb begin
        unique case (n_phase)
            pbsd_pkg::ST_IDLE:     n_phase_code = pbsd_pkg::PH_CODE_IDLE;
            pbsd_pkg::ST_FIRST:    n_phase_code = pbsd_pkg::PH_CODE_FIRST;
            pbsd_pkg::ST_RELEASED: n_phase_code = pbsd_pkg::PH_CODE_RELEASED;
            pbsd_pkg::ST_SECOND:   n_phase_code = pbsd_pkg::PH_CODE_SECOND;
            default:               n_phase_code = pbsd_pkg::PH_CODE_IDLE;
        endcase
    end

    // Input register: load on accept, drop when moved on
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_in_beat <= i_in_data;
        end
    end

    // Result register and state: advance together
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid   <= 1'b0;
            r_phase       <= pbsd_pkg::ST_IDLE;
            r_phase_start <= '0;
            r_fault_start <= '0;
            r_shutdown    <= 1'b0;
        end else begin
            if (out_room) begin
                r_out_valid <= r_in_valid;
            end
            if (advance) begin
                r_phase       <= n_phase;
                r_phase_start <= n_phase_start;
                r_fault_start <= n_fault_start;
                r_shutdown    <= n_shutdown;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_beat.shutdown_request <= n_shutdown;
            r_out_beat.fault_reset      <= n_fault;
            r_out_beat.sequence_phase   <= n_phase_code;
        end
    end

endmodule

`default_nettype wire
